// ===== rtl/pidti_pkg.sv =====
// Shared types and constants for the trapezoid-integral PID controller.
// No dependencies.
package pidti_pkg;

    localparam int GAIN_W    = 16;   // signed gain register width
    localparam int LIMIT_W   = 16;   // unsigned integral limit width
    localparam int DRIVE_W   = 32;   // saturated output width
    localparam int CFG_IDX_W = 3;    // configuration register index width

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd50;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SETPOINT  = 3'd0,
        CFG_GAIN_P    = 3'd1,
        CFG_GAIN_I    = 3'd2,
        CFG_GAIN_D    = 3'd3,
        CFG_INT_LIMIT = 3'd4
    } t_cfg_idx;

endpackage

// ===== rtl/pid_controller_trapezoid_integral.sv =====
// PID controller with trapezoid integral and windup guard, three-stage pipeline.
// Depends on pidti_pkg.
//
// An accepted request passes through stages A, B and C, then reaches the master side.
// Throughput: one request per cycle; each stage holds one request and advances
// whenever the stage after it is free or being drained, so only a stalled
// master side slows intake.
// Reset (i_rst_n low, synchronous): pipeline emptied, previous error and
// integral zeroed, setpoint and gains zeroed, integral limit set to 50.
module pid_controller_trapezoid_integral #(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int GAIN_FRAC_BITS = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,

    // Configuration write channel (always ready)
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pidti_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [((SAMPLE_WIDTH > pidti_pkg::GAIN_W) ?
                   SAMPLE_WIDTH : pidti_pkg::GAIN_W)-1:0] i_cfg_data,

    // Sample stream in
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   s_axis_tdata,  // [SAMPLE_WIDTH-1:0] measured
    input  logic [0:0]                          s_axis_tuser,  // [0] restart

    // Drive stream out
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [pidti_pkg::DRIVE_W-1:0]       m_axis_tdata,  // [31:0] drive
    output logic [0:0]                          m_axis_tuser   // [0] windup_cleared
);
    import pidti_pkg::*;

    localparam int ERR_W   = SAMPLE_WIDTH + 1;       // setpoint - measured
    localparam int DIFF_W  = ERR_W + 1;              // error - previous error
    localparam int INTEG_W = SAMPLE_WIDTH + 4;       // integral in half units
    localparam int LIM2_W  = LIMIT_W + 1;            // twice the limit
    localparam int CMP_W   = (INTEG_W > LIM2_W) ? INTEG_W : LIM2_W;
    localparam int P_W     = GAIN_W + ERR_W;
    localparam int D_W     = GAIN_W + DIFF_W;
    localparam int I_W     = GAIN_W + INTEG_W;
    localparam int SUM_RAW = GAIN_W + INTEG_W + 2;
    localparam int SUM_W   = (SUM_RAW > DRIVE_W + 1) ? SUM_RAW : DRIVE_W + 1;
    localparam int SHIFT   = GAIN_FRAC_BITS + 1;     // Q frac bits plus the half unit
    localparam int HI_W    = SUM_W - DRIVE_W + 1;

    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = {1'b0, {(DRIVE_W-1){1'b1}}};
    localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = {1'b1, {(DRIVE_W-1){1'b0}}};

    // ---------------- configuration registers ----------------
    logic signed [SAMPLE_WIDTH-1:0] r_setpoint;
    logic signed [GAIN_W-1:0]       r_gain_p;
    logic signed [GAIN_W-1:0]       r_gain_i;
    logic signed [GAIN_W-1:0]       r_gain_d;
    logic        [LIMIT_W-1:0]      r_limit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint <= '0;
            r_gain_p   <= '0;
            r_gain_i   <= '0;
            r_gain_d   <= '0;
            r_limit    <= LIMIT_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SETPOINT:  r_setpoint <= i_cfg_data[SAMPLE_WIDTH-1:0];
                CFG_GAIN_P:    r_gain_p   <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_I:    r_gain_i   <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_D:    r_gain_d   <= i_cfg_data[GAIN_W-1:0];
                CFG_INT_LIMIT: r_limit    <= i_cfg_data[LIMIT_W-1:0];
                default: ;     // unused index: write dropped
            endcase
        end
    end

    // ---------------- pipeline flow control ----------------
    // Per-stage ready so a bubble ahead of a stalled output still fills.
    logic r_a_valid, r_b_valid, r_c_valid;
    logic ready_a, ready_b, ready_c;
    logic s_accept;

    assign ready_c       = !r_c_valid || m_axis_tready;
    assign ready_b       = !r_b_valid || ready_c;
    assign ready_a       = !r_a_valid || ready_b;
    assign s_axis_tready = ready_a;
    assign s_accept      = s_axis_tvalid && ready_a;

    // ---------------- stage A: error, integral, state update ----------------
    logic signed [ERR_W-1:0]   r_prev_err;
    logic signed [INTEG_W-1:0] r_integ;

    logic signed [SAMPLE_WIDTH-1:0] meas;
    logic                           restart;
    logic signed [ERR_W-1:0]        prev_eff;
    logic signed [INTEG_W-1:0]      integ_eff;
    logic        [INTEG_W-1:0]      integ_abs;
    logic        [LIM2_W-1:0]       lim2;
    logic                           below;
    logic signed [ERR_W-1:0]        n_err;
    logic signed [INTEG_W-1:0]      n_integ;
    logic signed [DIFF_W-1:0]       n_diff;

    assign meas    = s_axis_tdata[SAMPLE_WIDTH-1:0];
    assign restart = s_axis_tuser[0];

    always_comb begin
        // restart clears the state ahead of this sample
        prev_eff  = restart ? '0 : r_prev_err;
        integ_eff = restart ? '0 : r_integ;
        n_err     = {r_setpoint[SAMPLE_WIDTH-1], r_setpoint} - {meas[SAMPLE_WIDTH-1], meas};
        // guard works on |integral halves| < 2*limit; most-negative value maps
        // to its true magnitude as an unsigned number
        integ_abs = integ_eff[INTEG_W-1] ? INTEG_W'(-integ_eff) : INTEG_W'(integ_eff);
        lim2      = {r_limit, 1'b0};
        below     = CMP_W'(integ_abs) < CMP_W'(lim2);
        n_integ   = below
                  ? integ_eff
                    + {{(INTEG_W-ERR_W){n_err[ERR_W-1]}}, n_err}
                    + {{(INTEG_W-ERR_W){prev_eff[ERR_W-1]}}, prev_eff}
                  : '0;
        n_diff    = {n_err[ERR_W-1], n_err} - {prev_eff[ERR_W-1], prev_eff};
    end

    logic signed [ERR_W-1:0]   r_a_err;
    logic signed [DIFF_W-1:0]  r_a_diff;
    logic signed [INTEG_W-1:0] r_a_integ;
    logic                      r_a_clr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_err <= '0;
            r_integ    <= '0;
            r_a_valid  <= 1'b0;
        end else begin
            if (s_accept) begin
                r_prev_err <= n_err;
                r_integ    <= n_integ;
            end
            if (ready_a) begin
                r_a_valid <= s_axis_tvalid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_a_err   <= n_err;
            r_a_diff  <= n_diff;
            r_a_integ <= n_integ;
            r_a_clr   <= !below;
        end
    end

    // ---------------- stage B: the three products ----------------
    logic signed [P_W-1:0] r_b_p, n_b_p;
    logic signed [D_W-1:0] r_b_d, n_b_d;
    logic signed [I_W-1:0] r_b_i, n_b_i;
    logic                  r_b_clr;

    assign n_b_p = r_gain_p * r_a_err;
    assign n_b_d = r_gain_d * r_a_diff;
    assign n_b_i = r_gain_i * r_a_integ;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (ready_b) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_b && r_a_valid) begin
            r_b_p   <= n_b_p;
            r_b_d   <= n_b_d;
            r_b_i   <= n_b_i;
            r_b_clr <= r_a_clr;
        end
    end

    // ---------------- stage C: sum, floor, saturate ----------------
    // P and D terms are doubled to share the integral's half-unit scale.
    logic signed [SUM_W-1:0]   n_sum;
    logic signed [SUM_W-1:0]   n_q;
    logic        [HI_W-1:0]    q_hi;
    logic signed [DRIVE_W-1:0] n_drive;

    always_comb begin
        n_sum = (SUM_W'(r_b_p) <<< 1) + (SUM_W'(r_b_d) <<< 1) + SUM_W'(r_b_i);
        n_q   = n_sum >>> SHIFT;       // arithmetic shift floors toward minus infinity
        q_hi  = n_q[SUM_W-1:DRIVE_W-1];
        if (q_hi == '0 || q_hi == '1) begin
            n_drive = n_q[DRIVE_W-1:0];
        end else if (n_q[SUM_W-1]) begin
            n_drive = DRIVE_MIN;
        end else begin
            n_drive = DRIVE_MAX;
        end
    end

    logic signed [DRIVE_W-1:0] r_c_drive;
    logic                      r_c_clr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (ready_c) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_c && r_b_valid) begin
            r_c_drive <= n_drive;
            r_c_clr   <= r_b_clr;
        end
    end

    assign m_axis_tvalid   = r_c_valid;
    assign m_axis_tdata    = r_c_drive;
    assign m_axis_tuser[0] = r_c_clr;

`ifndef ASSERT_OFF
    // an accepted request always lands in stage A
    a_accept_to_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> r_a_valid)
        else $error("accepted request did not enter stage A");

    // stage A's integral copy tracks the live integral state
    a_integ_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid |-> (r_a_integ == r_integ))
        else $error("stage A integral differs from integral state");

    // windup flag implies the integral was zeroed
    a_clr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && r_a_clr) |-> (r_a_integ == '0))
        else $error("windup flagged with nonzero integral");

    // a stalled stage B never drops its request
    a_b_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && !ready_b) |=> r_b_valid)
        else $error("stage B request lost under stall");
`endif

endmodule
